FILE: rtl/greedy_box_suppression_defines.svh
// Assertion macros for the greedy box suppression block.
`ifndef GREEDY_BOX_SUPPRESSION_DEFINES_SVH
`define GREEDY_BOX_SUPPRESSION_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define GBS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define GBS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define GBS_ASSERT_IMP(label, ante, cons, msg)
`define GBS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

FILE: rtl/gbs_pkg.sv
`timescale 1ns / 1ps

package gbs_pkg;

	localparam int MAX_KEPT_DEF = 64;
	localparam int MAX_SET_DEF  = 1024;

	localparam logic [7:0] THR_RESET = 8'd102;

	typedef struct packed {
		logic [31:0]        area;
		logic [15:0]        h;
		logic [15:0]        w;
		logic signed [15:0] y;
		logic signed [15:0] x;
	} box_entry_t;

	typedef struct packed {
		logic busy;
		logic hit;
	} iou_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_AREA,
		ST_SCAN,
		ST_DRAIN,
		ST_DECIDE
	} gbs_state_t;

endpackage

FILE: rtl/gbs_store.sv
`timescale 1ns / 1ps

module gbs_store import gbs_pkg::*; #(
	parameter int MAX_KEPT = MAX_KEPT_DEF,
	parameter int AW       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  box_entry_t    wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output box_entry_t    rd_data
);

	box_entry_t mem [MAX_KEPT];
	box_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: rtl/gbs_iou.sv
`timescale 1ns / 1ps

module gbs_iou import gbs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  thr,
	input  box_entry_t  cand,
	input  logic        rd_en,
	input  box_entry_t  kept,
	output iou_status_t status
);

	// overlap of [a0, a0+al) and [b0, b0+bl), zero when disjoint
	function automatic logic [15:0] overlap(input logic signed [15:0] a0,
		input logic [15:0] al, input logic signed [15:0] b0, input logic [15:0] bl);
		logic signed [17:0] a1;
		logic signed [17:0] b1;
		logic signed [17:0] lo;
		logic signed [17:0] hi;
		logic signed [17:0] diff;
		a1 = 18'(a0) + signed'({2'b00, al});
		b1 = 18'(b0) + signed'({2'b00, bl});
		lo = (a0 > b0) ? 18'(a0) : 18'(b0);
		hi = (a1 < b1) ? a1 : b1;
		diff = hi - lo;
		return (hi > lo) ? diff[15:0] : 16'd0;
	endfunction

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [15:0] ox_s2, oy_s2;
	logic [31:0] karea_s2, karea_s3;
	logic [31:0] inter_s3, inter_s4, inter_s5;
	logic [32:0] uni_s4;
	logic [40:0] prod_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		ox_s2    <= overlap(cand.x, cand.w, kept.x, kept.w);
		oy_s2    <= overlap(cand.y, cand.h, kept.y, kept.h);
		karea_s2 <= kept.area;
		inter_s3 <= 32'(ox_s2) * 32'(oy_s2);
		karea_s3 <= karea_s2;
		uni_s4   <= {1'b0, cand.area} + {1'b0, karea_s3} - {1'b0, inter_s3};
		inter_s4 <= inter_s3;
		prod_s5  <= 41'(thr) * 41'(uni_s4);
		inter_s5 <= inter_s4;
	end

	assign status.hit  = v_s5 && ({1'b0, inter_s5, 8'd0} > prod_s5);
	assign status.busy = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;

endmodule

FILE: rtl/greedy_box_suppression.sv
// Boxes are taken one at a time: a new box is accepted only once the previous one is decided;
// the kept-box memory is scanned one entry a cycle through a five-stage overlap/compare
// pipeline; a full output register stalls.
// Next box is taken while a result waits in the output register.
// Reset (arst_n low): control state and counters cleared, threshold set to 102;
// the kept-box memory is not cleared and holds stale entries until rewritten.
`timescale 1ns / 1ps
`include "greedy_box_suppression_defines.svh"

module greedy_box_suppression import gbs_pkg::*; #(
	parameter int MAX_KEPT = MAX_KEPT_DEF,
	parameter int MAX_SET  = MAX_SET_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // box_x, box_y, box_w, box_h
	input  logic [0:0]  s_axis_tuser,  // first_of_set
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // keep, box_index, store_full, zero pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data       // iou_threshold
);

	localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
	localparam int CW = $clog2(MAX_KEPT + 1);
	localparam int PW = $clog2(MAX_SET);

	gbs_state_t  state_q, state_d;
	logic [7:0]  thr_q;
	logic [CW-1:0] count_q, rd_ptr_q;
	logic [PW-1:0] pos_q;
	logic        suppress_q;
	logic signed [15:0] x_q, y_q;
	logic [15:0] w_q, h_q;
	logic [31:0] area_q;
	logic        out_valid_q, keep_q, full_q;
	logic [9:0]  idx_q;

	logic        in_acc, rd_en, wr_en, out_load, out_free, room;
	logic [PW+9:0] pos_ext;
	box_entry_t  cand, kept;
	iou_status_t st;

	assign in_acc   = s_axis_tvalid && s_axis_tready;
	assign out_free = !out_valid_q || m_axis_tready;
	assign room     = count_q < CW'(MAX_KEPT);
	assign pos_ext  = {10'd0, pos_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_acc) state_d = ST_AREA;
			ST_AREA:   state_d = ST_SCAN;
			ST_SCAN:   if (rd_ptr_q >= count_q) state_d = ST_DRAIN;
			ST_DRAIN:  if (!st.busy) state_d = ST_DECIDE;
			ST_DECIDE: if (out_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		rd_en         = 1'b0;
		out_load      = 1'b0;
		wr_en         = 1'b0;
		case (state_q)
			ST_IDLE:   s_axis_tready = 1'b1;
			ST_SCAN:   rd_en = rd_ptr_q < count_q;
			ST_DECIDE: begin
				out_load = out_free;
				wr_en    = out_free && !suppress_q && room;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			thr_q       <= THR_RESET;
			count_q     <= '0;
			pos_q       <= '0;
			rd_ptr_q    <= '0;
			suppress_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			if (in_acc) begin
				suppress_q <= 1'b0;
				rd_ptr_q   <= '0;
				if (s_axis_tuser[0]) begin
					count_q <= '0;
					pos_q   <= '0;
				end
			end else begin
				suppress_q <= suppress_q | st.hit;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en) begin
				count_q <= count_q + 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
				if ({1'b0, pos_q} + 1'b1 >= (PW+1)'(MAX_SET)) begin
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q <= s_axis_tdata[15:0];
			y_q <= s_axis_tdata[31:16];
			w_q <= s_axis_tdata[47:32];
			h_q <= s_axis_tdata[63:48];
		end
		if (state_q == ST_AREA) begin
			area_q <= 32'(w_q) * 32'(h_q);
		end
		if (out_load) begin
			keep_q <= !suppress_q && room;
			full_q <= !suppress_q && !room;
			idx_q  <= pos_ext[9:0];
		end
	end

	assign cand = '{area: area_q, h: h_q, w: w_q, y: y_q, x: x_q};

	gbs_store #(
		.MAX_KEPT (MAX_KEPT),
		.AW       (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (count_q[AW-1:0]),
		.wr_data (cand),
		.rd_en   (rd_en),
		.rd_addr (rd_ptr_q[AW-1:0]),
		.rd_data (kept)
	);

	gbs_iou u_iou (
		.clk    (clk),
		.arst_n (arst_n),
		.thr    (thr_q),
		.cand   (cand),
		.rd_en  (rd_en),
		.kept   (kept),
		.status (st)
	);

	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'd0, full_q, idx_q, keep_q};

	`GBS_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(MAX_KEPT), "kept count above bound")
	`GBS_ASSERT_IMP(a_write_room, wr_en, room && !suppress_q, "store write without room")
	`GBS_ASSERT_IMP(a_keep_full, m_axis_tvalid, !(keep_q && full_q), "keep and full both set")
	`GBS_ASSERT_NEXT(a_accept_area, in_acc, state_q == ST_AREA, "accept did not start box")
	`GBS_ASSERT_IMP(a_scan_quiet, st.busy, state_q == ST_SCAN || state_q == ST_DRAIN,
		"compare pipeline busy outside scan")

endmodule
